// ===== rtl/dnm_pkg.sv =====
// Shared types and constants for the depth normal map unit.
// Holds line store sizing, register indexes and the beat structs passed
// between the window, geometry, square root and normalize stages.
package dnm_pkg;

    // Line store depth and address width
    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);

    // Pipelined square root and divider lengths (one result bit per stage)
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 15;

    // Configuration register indexes
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_PRINCIPAL_X  = 3'd2;
    localparam logic [2:0] REG_PRINCIPAL_Y  = 3'd3;
    localparam logic [2:0] REG_INV_FOCAL_X  = 3'd4;
    localparam logic [2:0] REG_INV_FOCAL_Y  = 3'd5;

    // Center pixel position and early validity
    typedef struct packed {
        logic        ok;
        logic [11:0] col;
        logic [11:0] row;
    } tag_t;

    // Neighborhood depths around one center pixel
    typedef struct packed {
        logic [15:0] mc;
        logic [15:0] pc;
        logic [15:0] cm;
        logic [15:0] cp;
        tag_t        tag;
    } win_t;

    // Cross product magnitudes, scaled below 2^30, and their signs
    typedef struct packed {
        tag_t        tag;
        logic [2:0]  neg;
        logic [29:0] mx;
        logic [29:0] my;
        logic [29:0] mz;
    } vec_t;

    // One result beat
    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               normal_valid;
        logic [11:0]        center_col;
        logic [11:0]        center_row;
    } res_t;

endpackage

// ===== rtl/dnm_window.sv =====
// Raster counters, two line stores and the 3x3 cross neighborhood window.
// Depends on dnm_pkg for store sizing and the window beat struct.
module dnm_window (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           cfg_wr,
    input  logic [15:0]    depth,
    input  logic           depth_present,
    input  logic [12:0]    width_eff,
    input  logic [12:0]    height_eff,
    output logic           out_valid,
    output dnm_pkg::win_t  out_win
);

    localparam int AW = dnm_pkg::ADDR_W;

    logic [16:0] above_mem [dnm_pkg::MAX_WIDTH];
    logic [16:0] two_mem   [dnm_pkg::MAX_WIDTH];

    logic        acc;
    logic [11:0] col_reg, row_reg;
    logic [11:0] col_next, row_next;
    logic [16:0] prev_reg;
    logic [12:0] col_w, row_w, col_inc, row_inc, rd_addr, wr_addr, cr_w;
    logic        emit, geom_ok, wr_in;
    logic [1:0]  prime_reg;
    logic [12:0] rd_sel;
    logic        rd_sel_in;

    logic [16:0] rd_above_reg, rd_two_reg;
    logic        rd_in_reg;
    logic [16:0] above_eff, two_eff;
    logic [16:0] a1_reg, a2_reg, t1_reg;

    logic        s1_valid_reg, s1_ok_reg;
    logic [11:0] s1_col_reg, s1_cr_reg;
    logic [16:0] s1_cp_reg;

    logic          out_valid_reg;
    dnm_pkg::win_t win_reg;
    logic          all_present;

    // Hold input while the read history is reloaded after a register write
    assign in_ready = (prime_reg == 2'd0);
    assign acc      = in_valid & en & in_ready;

    // Position of this pixel, store addresses and next position
    always_comb
    begin
        col_w = {1'b0, col_reg};
        row_w = {1'b0, row_reg};
        if (col_w >= width_eff)
        begin
            col_w = '0;
            row_w = row_w + 13'd1;
        end
        if (row_w >= height_eff)
        begin
            row_w = '0;
        end
        col_inc = col_w + 13'd1;
        row_inc = row_w + 13'd1;
        rd_addr = (col_inc == width_eff) ? '0 : col_inc;
        wr_addr = (col_w == '0) ? width_eff - 13'd1 : col_w - 13'd1;
        wr_in   = wr_addr < 13'(dnm_pkg::MAX_WIDTH);
        emit    = row_w != '0;
        cr_w    = row_w - 13'd1;
        geom_ok = (col_w != '0) && (col_inc < width_eff) && (cr_w != '0);
        if (col_inc >= width_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= height_eff) ? '0 : row_inc[11:0];
        end
        else
        begin
            col_next = col_inc[11:0];
            row_next = row_w[11:0];
        end
        // Reload reads the left column, then the current column
        if (prime_reg == 2'd2)
            rd_sel = wr_addr;
        else if (prime_reg == 2'd1)
            rd_sel = col_w;
        else
            rd_sel = rd_addr;
        rd_sel_in = rd_sel < 13'(dnm_pkg::MAX_WIDTH);
    end

    // Reload sequence after every register write, counting prime_reg down from 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_reg <= 2'd0;
        end
        else if (cfg_wr)
        begin
            prime_reg <= 2'd2;
        end
        else if (prime_reg != 2'd0)
        begin
            prime_reg <= prime_reg - 2'd1;
        end
    end

    // Line stores: delayed write one column back, read one column ahead
    always_ff @(posedge clk)
    begin
        if (acc && wr_in)
        begin
            above_mem[wr_addr[AW-1:0]] <= prev_reg;
            two_mem[wr_addr[AW-1:0]]   <= a1_reg;
        end
        if (acc || (prime_reg != 2'd0))
        begin
            rd_above_reg <= above_mem[rd_sel[AW-1:0]];
            rd_two_reg   <= two_mem[rd_sel[AW-1:0]];
        end
    end

    assign above_eff = rd_in_reg ? rd_above_reg : '0;
    assign two_eff   = rd_in_reg ? rd_two_reg : '0;

    // Advance counters and the read history on every accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            prev_reg  <= '0;
            rd_in_reg <= 1'b0;
            a1_reg    <= '0;
            a2_reg    <= '0;
            t1_reg    <= '0;
        end
        else if (acc)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            prev_reg  <= {depth_present, depth};
            rd_in_reg <= rd_sel_in;
            a1_reg    <= above_eff;
            a2_reg    <= a1_reg;
            t1_reg    <= two_eff;
        end
        else if (prime_reg != 2'd0)
        begin
            rd_in_reg <= rd_sel_in;
            if (prime_reg == 2'd1)
                a1_reg <= above_eff;
        end
    end

    // Stage one: hold the center beat while the store read lands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= acc & emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ok_reg  <= geom_ok;
            s1_col_reg <= col_w[11:0];
            s1_cr_reg  <= cr_w[11:0];
            s1_cp_reg  <= {depth_present, depth};
        end
    end

    // Stage two: capture the neighborhood and check for missing depth
    assign all_present = a2_reg[16] & a1_reg[16] & above_eff[16] & t1_reg[16] & s1_cp_reg[16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            win_reg.mc      <= a2_reg[15:0];
            win_reg.pc      <= above_eff[15:0];
            win_reg.cm      <= t1_reg[15:0];
            win_reg.cp      <= s1_cp_reg[15:0];
            win_reg.tag.ok  <= s1_ok_reg & all_present;
            win_reg.tag.col <= s1_col_reg;
            win_reg.tag.row <= s1_cr_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_win   = win_reg;

endmodule

// ===== rtl/dnm_geom.sv =====
// Back-projection, difference vectors, cross product and magnitude scaling.
// Depends on dnm_pkg for the window and vector beat structs.
module dnm_geom (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  dnm_pkg::win_t  in_win,
    input  logic [15:0]    principal_x,
    input  logic [15:0]    principal_y,
    input  logic [23:0]    inv_focal_x,
    input  logic [23:0]    inv_focal_y,
    output logic           out_valid,
    output dnm_pkg::vec_t  out_vec
);

    localparam int LANES = 8;
    localparam int STAGES = 9;
    // Lanes projecting along y: 2, 3, 6, 7
    localparam logic [LANES-1:0] LANE_IS_Y = 8'b1100_1100;
    localparam logic signed [34:0] LIM = 35'sd1073741823;

    function automatic logic signed [30:0] sat30(input logic signed [34:0] v);
        logic signed [30:0] r;
        if (v > LIM)
            r = 31'sd1073741823;
        else if (v < -LIM)
            r = -31'sd1073741823;
        else
            r = v[30:0];
        return r;
    endfunction

    logic          vld_reg [1:STAGES];
    dnm_pkg::tag_t tag_reg [1:STAGES];

    // Lane selection
    logic [12:0]        col13, cr13;
    logic [15:0]        lane_d   [LANES];
    logic [12:0]        lane_pos [LANES];
    logic signed [17:0] lane_t   [LANES];
    logic [16:0]        lane_abs [LANES];
    logic signed [20:0] az_c, bz_c;

    logic [16:0]        g1_abs_reg [LANES];
    logic [15:0]        g1_d_reg   [LANES];
    logic [LANES-1:0]   neg_reg    [1:3];
    logic signed [20:0] az_reg     [1:4];
    logic signed [20:0] bz_reg     [1:4];
    logic [32:0]        g2_m_reg   [LANES];
    logic [44:0]        g3_ph_reg  [LANES];
    logic [44:0]        g3_pl_reg  [LANES];
    logic [56:0]        full_c     [LANES];
    logic signed [33:0] lat_c      [LANES];
    logic signed [33:0] g4_lat_reg [LANES];
    logic signed [30:0] ax_reg, ay_reg, azs_reg, bx_reg, by_reg, bzs_reg;
    logic signed [61:0] p_reg [6];
    logic signed [62:0] c_c   [3];
    logic [61:0]        g7_mag_reg [3];
    logic [2:0]         g7_neg_reg;
    logic [61:0]        orv;
    logic [5:0]         msb;
    logic [5:0]         g8_s_reg;
    logic [61:0]        g8_mag_reg [3];
    logic [2:0]         g8_neg_reg;
    dnm_pkg::vec_t      vec_reg;

    // Pick depth, position and center for each back-projected coordinate
    always_comb
    begin
        col13 = {1'b0, in_win.tag.col};
        cr13  = {1'b0, in_win.tag.row};
        lane_d[0] = in_win.pc;  lane_pos[0] = col13 + 13'd1;
        lane_d[1] = in_win.mc;  lane_pos[1] = col13 - 13'd1;
        lane_d[2] = in_win.pc;  lane_pos[2] = cr13;
        lane_d[3] = in_win.mc;  lane_pos[3] = cr13;
        lane_d[4] = in_win.cp;  lane_pos[4] = col13;
        lane_d[5] = in_win.cm;  lane_pos[5] = col13;
        lane_d[6] = in_win.cp;  lane_pos[6] = cr13 + 13'd1;
        lane_d[7] = in_win.cm;  lane_pos[7] = cr13 - 13'd1;
        for (int k = 0; k < LANES; k++)
        begin
            lane_t[k] = $signed({1'b0, lane_pos[k], 4'b0000})
                      - $signed({2'b00, (LANE_IS_Y[k] ? principal_y : principal_x)});
            lane_abs[k] = (lane_t[k] < 0) ? 17'(-lane_t[k]) : 17'(lane_t[k]);
        end
        az_c = ($signed({5'b0, in_win.pc}) - $signed({5'b0, in_win.mc})) <<< 4;
        bz_c = ($signed({5'b0, in_win.cp}) - $signed({5'b0, in_win.cm})) <<< 4;
    end

    // Round the lateral coordinate and apply its sign
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            full_c[k] = ({12'b0, g3_ph_reg[k]} << 12) + {12'b0, g3_pl_reg[k]}
                      + 57'd8388608;
            lat_c[k]  = neg_reg[3][k] ? -$signed({1'b0, full_c[k][56:24]})
                                      : $signed({1'b0, full_c[k][56:24]});
        end
    end

    // Cross product differences and the common scale-down amount
    always_comb
    begin
        c_c[0] = {p_reg[0][61], p_reg[0]} - {p_reg[1][61], p_reg[1]};
        c_c[1] = {p_reg[2][61], p_reg[2]} - {p_reg[3][61], p_reg[3]};
        c_c[2] = {p_reg[4][61], p_reg[4]} - {p_reg[5][61], p_reg[5]};
        orv = g7_mag_reg[0] | g7_mag_reg[1] | g7_mag_reg[2];
        msb = '0;
        for (int i = 0; i < 62; i++)
        begin
            if (orv[i])
                msb = 6'(i);
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= STAGES; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[1] <= in_valid;
            for (int s = 2; s <= STAGES; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[1] <= in_win.tag;
            for (int s = 2; s <= STAGES; s++)
                tag_reg[s] <= tag_reg[s-1];

            // Offset magnitudes
            for (int k = 0; k < LANES; k++)
            begin
                g1_abs_reg[k] <= lane_abs[k];
                g1_d_reg[k]   <= lane_d[k];
                neg_reg[1][k] <= lane_t[k] < 0;
            end
            az_reg[1] <= az_c;
            bz_reg[1] <= bz_c;
            neg_reg[2] <= neg_reg[1];
            neg_reg[3] <= neg_reg[2];
            for (int s = 2; s <= 4; s++)
            begin
                az_reg[s] <= az_reg[s-1];
                bz_reg[s] <= bz_reg[s-1];
            end

            // Offset times depth, then times the focal reciprocal in halves
            for (int k = 0; k < LANES; k++)
            begin
                g2_m_reg[k]  <= 33'(g1_abs_reg[k]) * 33'(g1_d_reg[k]);
                g3_ph_reg[k] <= 45'(g2_m_reg[k])
                              * 45'(LANE_IS_Y[k] ? inv_focal_y[23:12] : inv_focal_x[23:12]);
                g3_pl_reg[k] <= 45'(g2_m_reg[k])
                              * 45'(LANE_IS_Y[k] ? inv_focal_y[11:0] : inv_focal_x[11:0]);
                g4_lat_reg[k] <= lat_c[k];
            end

            // Saturated difference vectors
            ax_reg  <= sat30({g4_lat_reg[0][33], g4_lat_reg[0]}
                           - {g4_lat_reg[1][33], g4_lat_reg[1]});
            ay_reg  <= sat30({g4_lat_reg[2][33], g4_lat_reg[2]}
                           - {g4_lat_reg[3][33], g4_lat_reg[3]});
            bx_reg  <= sat30({g4_lat_reg[4][33], g4_lat_reg[4]}
                           - {g4_lat_reg[5][33], g4_lat_reg[5]});
            by_reg  <= sat30({g4_lat_reg[6][33], g4_lat_reg[6]}
                           - {g4_lat_reg[7][33], g4_lat_reg[7]});
            azs_reg <= {{10{az_reg[4][20]}}, az_reg[4]};
            bzs_reg <= {{10{bz_reg[4][20]}}, bz_reg[4]};

            // Cross product partial terms
            p_reg[0] <= ay_reg * bzs_reg;
            p_reg[1] <= azs_reg * by_reg;
            p_reg[2] <= azs_reg * bx_reg;
            p_reg[3] <= ax_reg * bzs_reg;
            p_reg[4] <= ax_reg * by_reg;
            p_reg[5] <= ay_reg * bx_reg;

            // Magnitudes and signs
            for (int c = 0; c < 3; c++)
            begin
                g7_mag_reg[c] <= (c_c[c] < 0) ? 62'(-c_c[c]) : 62'(c_c[c]);
                g7_neg_reg[c] <= c_c[c] < 0;
            end

            // Shift amount that brings all magnitudes below 2^30
            g8_s_reg   <= (msb > 6'd29) ? msb - 6'd29 : 6'd0;
            g8_mag_reg <= g7_mag_reg;
            g8_neg_reg <= g7_neg_reg;

            // Apply the common shift
            vec_reg.tag <= tag_reg[8];
            vec_reg.neg <= g8_neg_reg;
            vec_reg.mx  <= 30'(g8_mag_reg[0] >> g8_s_reg);
            vec_reg.my  <= 30'(g8_mag_reg[1] >> g8_s_reg);
            vec_reg.mz  <= 30'(g8_mag_reg[2] >> g8_s_reg);
        end
    end

    assign out_valid = vld_reg[STAGES];
    assign out_vec   = vec_reg;

endmodule

// ===== rtl/dnm_sqrt.sv =====
// Sum of squares and a pipelined integer square root, one root bit per stage.
// Depends on dnm_pkg for the vector beat struct and the stage count.
module dnm_sqrt (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  dnm_pkg::vec_t  in_vec,
    output logic           out_valid,
    output dnm_pkg::vec_t  out_vec,
    output logic [30:0]    out_len
);

    localparam int STEPS = dnm_pkg::SQRT_STEPS;

    logic          q0_valid_reg;
    dnm_pkg::vec_t q0_vec_reg;
    logic [59:0]   sq_reg [3];

    logic          st_vld_reg  [0:STEPS];
    dnm_pkg::vec_t st_vec_reg  [0:STEPS];
    logic [61:0]   st_v_reg    [0:STEPS];
    logic [32:0]   st_rem_reg  [0:STEPS];
    logic [30:0]   st_root_reg [0:STEPS];

    logic [34:0]   bring [STEPS];
    logic [34:0]   trial [STEPS];
    logic          ge    [STEPS];
    logic [32:0]   rem_next  [STEPS];
    logic [30:0]   root_next [STEPS];

    // One restoring root step per stage, most significant bit pair first
    always_comb
    begin
        for (int j = 0; j < STEPS; j++)
        begin
            bring[j] = {st_rem_reg[j], st_v_reg[j][2*(STEPS-1-j)+1 -: 2]};
            trial[j] = {2'b00, st_root_reg[j], 2'b01};
            ge[j]    = bring[j] >= trial[j];
            rem_next[j]  = ge[j] ? 33'(bring[j] - trial[j]) : 33'(bring[j]);
            root_next[j] = {st_root_reg[j][29:0], ge[j]};
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q0_valid_reg <= 1'b0;
            for (int j = 0; j <= STEPS; j++)
                st_vld_reg[j] <= 1'b0;
        end
        else if (en)
        begin
            q0_valid_reg  <= in_valid;
            st_vld_reg[0] <= q0_valid_reg;
            for (int j = 0; j < STEPS; j++)
                st_vld_reg[j+1] <= st_vld_reg[j];
        end
    end

    // Squares, their sum, then the root stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q0_vec_reg <= in_vec;
            sq_reg[0]  <= 60'(in_vec.mx) * 60'(in_vec.mx);
            sq_reg[1]  <= 60'(in_vec.my) * 60'(in_vec.my);
            sq_reg[2]  <= 60'(in_vec.mz) * 60'(in_vec.mz);

            st_vec_reg[0]  <= q0_vec_reg;
            st_v_reg[0]    <= 62'(sq_reg[0]) + 62'(sq_reg[1]) + 62'(sq_reg[2]);
            st_rem_reg[0]  <= '0;
            st_root_reg[0] <= '0;

            for (int j = 0; j < STEPS; j++)
            begin
                st_vec_reg[j+1]  <= st_vec_reg[j];
                st_v_reg[j+1]    <= st_v_reg[j];
                st_rem_reg[j+1]  <= rem_next[j];
                st_root_reg[j+1] <= root_next[j];
            end
        end
    end

    assign out_valid = st_vld_reg[STEPS];
    assign out_vec   = st_vec_reg[STEPS];
    assign out_len   = st_root_reg[STEPS];

endmodule

// ===== rtl/dnm_norm.sv =====
// Pipelined rounding divide of each magnitude by the length, then the result beat.
// Depends on dnm_pkg for the vector and result structs and the stage count.
module dnm_norm (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  dnm_pkg::vec_t  in_vec,
    input  logic [30:0]    in_len,
    output logic           out_valid,
    output dnm_pkg::res_t  out_res
);

    localparam int STEPS = dnm_pkg::DIV_STEPS;

    logic          dv_vld_reg [0:STEPS];
    dnm_pkg::tag_t dv_tag_reg [0:STEPS];
    logic [2:0]    dv_neg_reg [0:STEPS];
    logic [30:0]   dv_len_reg [0:STEPS];
    logic [44:0]   dv_rem_reg [0:STEPS][3];
    logic [14:0]   dv_q_reg   [0:STEPS][3];

    logic [44:0]   dshift [STEPS];
    logic          ge     [STEPS][3];
    logic [29:0]   mag_in [3];
    dnm_pkg::tag_t tag_in;

    logic          out_valid_reg;
    dnm_pkg::res_t res_reg;
    logic [15:0]   q_ext [3];
    logic [15:0]   n_c   [3];

    assign mag_in[0] = in_vec.mx;
    assign mag_in[1] = in_vec.my;
    assign mag_in[2] = in_vec.mz;

    // Drop the valid flag when the length is zero
    always_comb
    begin
        tag_in    = in_vec.tag;
        tag_in.ok = in_vec.tag.ok & (in_len != '0);
    end

    // Compare against the shifted length, one quotient bit per stage
    always_comb
    begin
        for (int j = 0; j < STEPS; j++)
        begin
            dshift[j] = {14'b0, dv_len_reg[j]} << (STEPS - 1 - j);
            for (int c = 0; c < 3; c++)
                ge[j][c] = dv_rem_reg[j][c] >= dshift[j];
        end
    end

    // Signed components, zero when no normal was computed
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            q_ext[c] = {1'b0, dv_q_reg[STEPS][c]};
            if (!dv_tag_reg[STEPS].ok)
                n_c[c] = '0;
            else if (dv_neg_reg[STEPS][c])
                n_c[c] = -q_ext[c];
            else
                n_c[c] = q_ext[c];
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= STEPS; j++)
                dv_vld_reg[j] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dv_vld_reg[0] <= in_valid;
            for (int j = 0; j < STEPS; j++)
                dv_vld_reg[j+1] <= dv_vld_reg[j];
            out_valid_reg <= dv_vld_reg[STEPS];
        end
    end

    // Dividend setup with half the length for rounding, then divide stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_tag_reg[0]    <= tag_in;
            dv_neg_reg[0]    <= in_vec.neg;
            dv_len_reg[0]    <= in_len;
            for (int c = 0; c < 3; c++)
            begin
                dv_rem_reg[0][c] <= ({15'b0, mag_in[c]} << 14) + {15'b0, in_len[30:1]};
                dv_q_reg[0][c]   <= '0;
            end

            for (int j = 0; j < STEPS; j++)
            begin
                dv_tag_reg[j+1] <= dv_tag_reg[j];
                dv_neg_reg[j+1] <= dv_neg_reg[j];
                dv_len_reg[j+1] <= dv_len_reg[j];
                for (int c = 0; c < 3; c++)
                begin
                    dv_rem_reg[j+1][c] <= ge[j][c] ? dv_rem_reg[j][c] - dshift[j]
                                                   : dv_rem_reg[j][c];
                    dv_q_reg[j+1][c]   <= {dv_q_reg[j][c][13:0], ge[j][c]};
                end
            end

            res_reg.normal_x     <= n_c[0];
            res_reg.normal_y     <= n_c[1];
            res_reg.normal_z     <= n_c[2];
            res_reg.normal_valid <= dv_tag_reg[STEPS].ok;
            res_reg.center_col   <= dv_tag_reg[STEPS].col;
            res_reg.center_row   <= dv_tag_reg[STEPS].row;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== rtl/depth_normal_map_unit.sv =====
// Pipeline: a depth beat passes 2 window stages, 9 geometry stages, square and sum
// plus 31 root stages, divide setup plus 15 divide stages and the output register
// before its result beat shows on the master side.
// Throughput: one depth beat per cycle unless held; no result for beats on row 0.
// The whole pipeline advances together, held only by the output register stall;
// input is also held after each register write while the window reloads.
// Reset: counters, previous pixel and valid bits clear; registers take defaults;
// line store contents stay undefined until written.
module depth_normal_map_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] depth
    input  logic        s_axis_tuser,   // [0] depth_present
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [15:0] normal_x, [31:16] normal_y,
                                        // [47:32] normal_z, [59:48] center_col,
                                        // [71:60] center_row
    output logic        m_axis_tuser,   // [0] normal_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    function automatic logic [12:0] eff_size(input logic [12:0] v);
        logic [12:0] r;
        if (v > 13'd4096)
            r = 13'd4096;
        else if (v == 13'd0)
            r = 13'd1;
        else
            r = v;
        return r;
    endfunction

    logic [12:0] width_reg, height_reg;
    logic [15:0] principal_x_reg, principal_y_reg;
    logic [23:0] inv_focal_x_reg, inv_focal_y_reg;

    logic          en;
    logic          win_ready;
    logic          win_valid, geo_valid, sq_valid, res_valid;
    dnm_pkg::win_t win;
    dnm_pkg::vec_t geo_vec, sq_vec;
    logic [30:0]   sq_len;
    dnm_pkg::res_t res;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= 13'd640;
            height_reg      <= 13'd480;
            principal_x_reg <= 16'd5120;
            principal_y_reg <= 16'd3840;
            inv_focal_x_reg <= 24'd32263;
            inv_focal_y_reg <= 24'd32263;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dnm_pkg::REG_IMAGE_WIDTH:  width_reg       <= cfg_data[12:0];
                dnm_pkg::REG_IMAGE_HEIGHT: height_reg      <= cfg_data[12:0];
                dnm_pkg::REG_PRINCIPAL_X:  principal_x_reg <= cfg_data[15:0];
                dnm_pkg::REG_PRINCIPAL_Y:  principal_y_reg <= cfg_data[15:0];
                dnm_pkg::REG_INV_FOCAL_X:  inv_focal_x_reg <= cfg_data;
                dnm_pkg::REG_INV_FOCAL_Y:  inv_focal_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the pipeline unless the output beat is held
    assign en            = !res_valid || m_axis_tready;
    assign s_axis_tready = en & win_ready;

    dnm_window u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (s_axis_tvalid),
        .in_ready      (win_ready),
        .cfg_wr        (cfg_valid & cfg_ready),
        .depth         (s_axis_tdata),
        .depth_present (s_axis_tuser),
        .width_eff     (eff_size(width_reg)),
        .height_eff    (eff_size(height_reg)),
        .out_valid     (win_valid),
        .out_win       (win)
    );

    dnm_geom u_geom (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (win_valid),
        .in_win      (win),
        .principal_x (principal_x_reg),
        .principal_y (principal_y_reg),
        .inv_focal_x (inv_focal_x_reg),
        .inv_focal_y (inv_focal_y_reg),
        .out_valid   (geo_valid),
        .out_vec     (geo_vec)
    );

    dnm_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (geo_valid),
        .in_vec    (geo_vec),
        .out_valid (sq_valid),
        .out_vec   (sq_vec),
        .out_len   (sq_len)
    );

    dnm_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_vec    (sq_vec),
        .in_len    (sq_len),
        .out_valid (res_valid),
        .out_res   (res)
    );

    // Pack the result beat
    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = {res.center_row, res.center_col,
                            res.normal_z, res.normal_y, res.normal_x};
    assign m_axis_tuser  = res.normal_valid;

endmodule

// ===== tb/tb_depth_normal_map_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for depth_normal_map_unit: streams depth pixels, predicts
// each normal beat in a local fixed-point model and checks the master side.
// Depends on dnm_pkg for register indexes and the result beat struct.
module tb_depth_normal_map_unit;

    localparam int STORE_DEPTH = dnm_pkg::MAX_WIDTH;
    localparam int DRAIN_CYCLES = 70;
    localparam int CYCLE_LIMIT = 1000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    depth_normal_map_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Predictor state: registers, line stores, delayed pixel, raster position
    int unsigned img_w_reg = 640, img_h_reg = 480;
    int unsigned ppx = 5120, ppy = 3840, ifx = 32263, ify = 32263;
    logic [16:0] row_above [STORE_DEPTH];
    logic [16:0] row_two_above [STORE_DEPTH];
    logic [16:0] last_pixel = '0;
    int unsigned col_pos = 0, row_pos = 0;

    dnm_pkg::res_t normals_due[$];
    int   mismatches = 0;
    int   src_gap_max = 12;
    int   sink_gap_max = 12;
    int   sink_hold = 0;
    bit   beat_seen = 0;

    // Clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int unsigned clamp_size(int unsigned v);
        if (v > 4096) return 4096;
        if (v < 1) return 1;
        return v;
    endfunction

    // Back-project one lateral coordinate, Q.4 mm
    function automatic longint lateral_coord(logic [16:0] px, int unsigned pos,
                                             int unsigned ctr, int unsigned inv);
        longint            t;
        longint unsigned   mag;
        t = longint'(pos) * 16 - longint'(ctr);
        mag = longint'(t < 0 ? -t : t);
        mag = mag * longint'(px[15:0]) * longint'(inv);
        mag = (mag + (64'd1 << 23)) >> 24;
        return (t < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint clip30(longint v);
        longint lim;
        lim = (64'sd1 <<< 30) - 1;
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] unit_comp(longint unsigned mag, bit neg,
                                              longint unsigned len);
        longint q;
        q = longint'((mag * 16384 + (len >> 1)) / len);
        return neg ? 16'(-q) : 16'(q);
    endfunction

    function automatic logic [16:0] store_read(bit two, int unsigned idx);
        if (idx >= STORE_DEPTH) return '0;
        return two ? row_two_above[idx] : row_above[idx];
    endfunction

    // Advance the predictor by one accepted depth beat
    task automatic predict_normal(logic [15:0] d, logic p);
        int unsigned     w, h, col, row, cr, pcol;
        logic [16:0]     cur, mc, cc, pc, cm;
        longint          ax, ay, az, bx, by, bz, cx, cy, cz;
        longint unsigned mx, my, mz, len;
        dnm_pkg::res_t   r;
        w = clamp_size(img_w_reg);
        h = clamp_size(img_h_reg);
        col = col_pos;
        row = row_pos;
        cur = {p, d};
        if (col >= w)
        begin
            col = 0;
            row++;
        end
        if (row >= h) row = 0;
        if (row >= 1)
        begin
            cr = row - 1;
            r = '0;
            r.center_col = 12'(col);
            r.center_row = 12'(cr);
            if (col > 0 && col + 1 < w && cr > 0)
            begin
                mc = store_read(0, col - 1);
                cc = store_read(0, col);
                pc = store_read(0, col + 1);
                cm = store_read(1, col);
                if (mc[16] && cc[16] && pc[16] && cm[16] && cur[16])
                begin
                    ax = clip30(lateral_coord(pc, col + 1, ppx, ifx)
                                - lateral_coord(mc, col - 1, ppx, ifx));
                    ay = clip30(lateral_coord(pc, cr, ppy, ify)
                                - lateral_coord(mc, cr, ppy, ify));
                    az = clip30((longint'(pc[15:0]) - longint'(mc[15:0])) * 16);
                    bx = clip30(lateral_coord(cur, col, ppx, ifx)
                                - lateral_coord(cm, col, ppx, ifx));
                    by = clip30(lateral_coord(cur, cr + 1, ppy, ify)
                                - lateral_coord(cm, cr - 1, ppy, ify));
                    bz = clip30((longint'(cur[15:0]) - longint'(cm[15:0])) * 16);
                    cx = ay * bz - az * by;
                    cy = az * bx - ax * bz;
                    cz = ax * by - ay * bx;
                    mx = cx < 0 ? -cx : cx;
                    my = cy < 0 ? -cy : cy;
                    mz = cz < 0 ? -cz : cz;
                    while (mx >= (64'd1 << 30) || my >= (64'd1 << 30) || mz >= (64'd1 << 30))
                    begin
                        mx >>= 1;
                        my >>= 1;
                        mz >>= 1;
                    end
                    len = int_sqrt(mx * mx + my * my + mz * mz);
                    if (len > 0)
                    begin
                        r.normal_x = unit_comp(mx, cx < 0, len);
                        r.normal_y = unit_comp(my, cy < 0, len);
                        r.normal_z = unit_comp(mz, cz < 0, len);
                        r.normal_valid = 1'b1;
                    end
                end
            end
            normals_due = {normals_due, r};
        end
        // Delayed store write, one pixel behind
        pcol = (col == 0) ? w - 1 : col - 1;
        if (pcol < STORE_DEPTH)
        begin
            row_two_above[pcol] = row_above[pcol];
            row_above[pcol] = last_pixel;
        end
        last_pixel = cur;
        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end
        col_pos = col & 12'hFFF;
        row_pos = row & 12'hFFF;
    endtask

    // Send one depth beat after a random gap
    task automatic send_pixel(logic [15:0] d, logic p);
        int gap;
        bit ok;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= p;
        do
        begin
            @(negedge clk);
            ok = s_axis_tready;
            @(posedge clk);
        end
        while (!ok);
        predict_normal(d, p);
    endtask

    // Drop valid, wait for all due normals, then let the pipeline empty
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (normals_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] v);
        bit ok;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
        begin
            @(negedge clk);
            ok = cfg_ready;
            @(posedge clk);
        end
        while (!ok);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            dnm_pkg::REG_IMAGE_WIDTH:  img_w_reg = v & 24'h1FFF;
            dnm_pkg::REG_IMAGE_HEIGHT: img_h_reg = v & 24'h1FFF;
            dnm_pkg::REG_PRINCIPAL_X:  ppx = v & 24'hFFFF;
            dnm_pkg::REG_PRINCIPAL_Y:  ppy = v & 24'hFFFF;
            dnm_pkg::REG_INV_FOCAL_X:  ifx = v;
            dnm_pkg::REG_INV_FOCAL_Y:  ify = v;
            default: ;
        endcase
    endtask

    task automatic set_camera(int unsigned w, int unsigned h, int unsigned cx,
                              int unsigned cy, int unsigned fx, int unsigned fy);
        write_reg(dnm_pkg::REG_IMAGE_WIDTH, w);
        write_reg(dnm_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(dnm_pkg::REG_PRINCIPAL_X, cx);
        write_reg(dnm_pkg::REG_PRINCIPAL_Y, cy);
        write_reg(dnm_pkg::REG_INV_FOCAL_X, fx);
        write_reg(dnm_pkg::REG_INV_FOCAL_Y, fy);
    endtask

    // Depth on a tilted plane with noise; some holes and raw values
    function automatic logic [16:0] surface_pixel(int unsigned base, int gx, int gy);
        int unsigned sel;
        int          v;
        sel = $urandom_range(0, 99);
        if (sel < 8) return {1'b0, 16'($urandom)};
        if (sel < 12) return {1'b1, 16'($urandom)};
        v = int'(base) + gx * int'(col_pos) + gy * int'(row_pos)
            + $urandom_range(0, 40) - 20;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return {1'b1, 16'(v)};
    endfunction

    // Write every store column that later images use, three full rows
    task automatic test_store_fill;
        int unsigned i;
        set_camera(32, 3, 5120, 3840, 32263, 32263);
        for (i = 0; i < 3 * 32; i++)
            send_pixel(16'($urandom_range(400, 3000)), 1'b1);
        drain();
    endtask

    // Extremes, holes, zero depth, flat zero plane, odd register values
    task automatic test_directed;
        logic [16:0] pix [20];
        int          i;
        pix = '{17'h1FFFF, 17'h10000, 17'h1FFFF, 17'h10000, 17'h0FFFF,
                17'h10000, 17'h10000, 17'h10000, 17'h10000, 17'h10000,
                17'h10000, 17'h10000, 17'h00000, 17'h10000, 17'h10000,
                17'h1FFFF, 17'h1FFFF, 17'h10001, 17'h1FFFF, 17'h1FFFF};
        set_camera(5, 4, 0, 65535, 16777215, 1);
        for (i = 0; i < 20; i++)
            send_pixel(pix[i][15:0], pix[i][16]);
        drain();
        // Zero size acts as one, oversize acts as the limit
        set_camera(0, 8191, 65535, 0, 1, 16777215);
        for (i = 0; i < 4; i++)
            send_pixel(16'($urandom), 1'b1);
        drain();
        write_reg(dnm_pkg::REG_IMAGE_WIDTH, 8191);
        write_reg(dnm_pkg::REG_IMAGE_HEIGHT, 3);
        for (i = 0; i < 4; i++)
            send_pixel(16'($urandom), 1'b1);
        drain();
    endtask

    // Random camera settings and small images with random gaps
    task automatic test_random_frames;
        int          ph, i, gx, gy;
        int unsigned base, fsel;
        logic [16:0] px;
        for (ph = 0; ph < 9; ph++)
        begin
            fsel = $urandom_range(0, 3);
            set_camera((ph == 0) ? 3 : $urandom_range(3, 24),
                       (ph == 1) ? 3 : $urandom_range(3, 12),
                       $urandom_range(0, 65535), $urandom_range(0, 65535),
                       fsel == 0 ? 24'hFFFFFF : fsel == 1 ? 1 : $urandom_range(1, 24'hFFFFFF),
                       $urandom_range(1, 24'hFFFFFF));
            base = $urandom_range(0, 65535);
            gx = $urandom_range(0, 400) - 200;
            gy = $urandom_range(0, 400) - 200;
            src_gap_max = (ph % 3 == 2) ? 0 : 12;
            sink_gap_max = (ph % 4 == 3) ? 0 : 12;
            for (i = 0; i < 70; i++)
            begin
                px = surface_pixel(base, gx, gy);
                send_pixel(px[15:0], px[16]);
            end
            drain();
        end
        src_gap_max = 12;
        sink_gap_max = 12;
    endtask

    // Hold the sink off while the source streams back to back
    task automatic test_backpressure;
        int          i;
        logic [16:0] px;
        set_camera(16, 8, 128, 64, 32263, 40000);
        src_gap_max = 0;
        sink_hold = 300;
        for (i = 0; i < 140; i++)
        begin
            px = surface_pixel(1500, 7, -5);
            send_pixel(px[15:0], px[16]);
        end
        drain();
        src_gap_max = 12;
    endtask

    // Sink ready: long hold first, then a random wait per beat
    initial
    begin
        int sink_wait;
        sink_wait = 0;
        forever
        begin
            @(posedge clk);
            if (beat_seen)
            begin
                beat_seen = 0;
                sink_wait = $urandom_range(0, sink_gap_max);
            end
            if (sink_hold > 0)
            begin
                sink_hold--;
                m_axis_tready <= 1'b0;
            end
            else if (sink_wait > 0)
            begin
                sink_wait--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest due normal
    initial
    begin
        dnm_pkg::res_t exp_r;
        forever
        begin
            @(negedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                beat_seen = 1;
                if (normals_due.size() == 0)
                begin
                    $error("unexpected result beat: tdata=%h tuser=%b",
                           m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end
                else
                begin
                    exp_r = normals_due.pop_front();
                    if (m_axis_tdata[15:0] !== exp_r.normal_x)
                    begin
                        $error("normal_x exp %0d got %0d", exp_r.normal_x,
                               $signed(m_axis_tdata[15:0]));
                        mismatches++;
                    end
                    if (m_axis_tdata[31:16] !== exp_r.normal_y)
                    begin
                        $error("normal_y exp %0d got %0d", exp_r.normal_y,
                               $signed(m_axis_tdata[31:16]));
                        mismatches++;
                    end
                    if (m_axis_tdata[47:32] !== exp_r.normal_z)
                    begin
                        $error("normal_z exp %0d got %0d", exp_r.normal_z,
                               $signed(m_axis_tdata[47:32]));
                        mismatches++;
                    end
                    if (m_axis_tuser !== exp_r.normal_valid)
                    begin
                        $error("normal_valid exp %0d got %0d", exp_r.normal_valid,
                               m_axis_tuser);
                        mismatches++;
                    end
                    if (m_axis_tdata[59:48] !== exp_r.center_col)
                    begin
                        $error("center_col exp %0d got %0d", exp_r.center_col,
                               m_axis_tdata[59:48]);
                        mismatches++;
                    end
                    if (m_axis_tdata[71:60] !== exp_r.center_row)
                    begin
                        $error("center_row exp %0d got %0d", exp_r.center_row,
                               m_axis_tdata[71:60]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Cycle limit
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    // Test sequence
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_store_fill();
        test_directed();
        test_random_frames();
        test_backpressure();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dnm_pkg.sv
rtl/dnm_window.sv
rtl/dnm_geom.sv
rtl/dnm_sqrt.sv
rtl/dnm_norm.sv
rtl/depth_normal_map_unit.sv
tb/tb_depth_normal_map_unit.sv
